### rtl/core/seven_segment_digit_reader_macros.svh
`ifndef SEVEN_SEGMENT_DIGIT_READER_MACROS_SVH
`define SEVEN_SEGMENT_DIGIT_READER_MACROS_SVH

// check that holds outside reset
`define SSDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is asserted
`define SSDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ssdr_pkg.sv
`timescale 1ns / 1ps

package ssdr_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 512;

  localparam logic [7:0] LIT_VALUE = 8'd255;

  localparam logic [3:0] DIGIT_ONE = 4'd1;
  localparam logic [3:0] DIGIT_BAD = 4'd10;

  // floor(n/3) as (n * RECIP3) >> RECIP3_SHIFT, exact for n below 2048
  localparam logic [10:0] RECIP3       = 11'd1366;
  localparam int unsigned RECIP3_SHIFT = 12;

  localparam int unsigned NUM_PATTERNS = 9;

  localparam logic [6:0] SEG_PATTERN [NUM_PATTERNS] = '{
    7'h3F, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam logic [3:0] SEG_DIGIT [NUM_PATTERNS] = '{
    4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // segment bit positions
  localparam int unsigned SEG_A = 0;
  localparam int unsigned SEG_B = 1;
  localparam int unsigned SEG_C = 2;
  localparam int unsigned SEG_D = 3;
  localparam int unsigned SEG_E = 4;
  localparam int unsigned SEG_F = 5;
  localparam int unsigned SEG_G = 6;

  typedef struct packed {
    logic       lit;
    logic [8:0] w;
    logic [9:0] h;
    logic [7:0] xh;
    logic [7:0] t1;
    logic [8:0] t2;
  } geom_t;

  function automatic logic [3:0] classify(logic [8:0] w, logic [9:0] h, logic [6:0] segs);
    logic [10:0] w3;
    logic [3:0]  d;
    w3 = {1'b0, w, 1'b0} + {2'b00, w};
    d  = DIGIT_BAD;
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if (SEG_PATTERN[i] == segs) begin
        d = SEG_DIGIT[i];
      end
    end
    if (w3 < {1'b0, h}) begin
      d = DIGIT_ONE;
    end
    return d;
  endfunction

endpackage

### rtl/core/ssdr_if.sv
`timescale 1ns / 1ps

interface ssdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic [8:0] crop_width;
  logic [9:0] crop_height;

  modport source (output valid, output pixel, output crop_width, output crop_height,
                  input ready);
  modport sink   (input valid, input pixel, input crop_width, input crop_height,
                  output ready);
endinterface

interface ssdr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit;
  logic [6:0] segments;

  modport source (output valid, output digit, output segments, input ready);
  modport sink   (input valid, input digit, input segments, output ready);
endinterface

### rtl/core/seven_segment_digit_reader.sv
`timescale 1ns / 1ps
// channel  | direction | payload
// in_ch    | sink      | pixel, crop_width, crop_height
// out_ch   | source    | digit, segments (one item per crop, on its last pixel)
//
// one pixel a cycle unless held back; pixels pass the input register, and
// a crop's result is registered as its last pixel leaves the input register
// rst_n clears the counters, flags and both valid bits
// a pixel is held back only when the last pixel of a crop waits for a full
// result register that the sink does not take

module seven_segment_digit_reader
  import ssdr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  ssdr_in_if.sink    in_ch,
  ssdr_out_if.source out_ch
);

`include "seven_segment_digit_reader_macros.svh"

  geom_t geom_in;
  geom_t s1_r;
  logic  s1_valid_r, s1_valid_nxt;

  logic [7:0] col_r, col_nxt;
  logic [8:0] row_r, row_nxt;
  logic [6:0] flags_r, flags_nxt, flags_upd;

  logic       col_end, row_end, s1_last, s1_go, in_acc, out_load;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_digit_r;
  logic [6:0] out_segs_r;

  ssdr_geom u_geom (
    .pixel      (in_ch.pixel),
    .crop_width (in_ch.crop_width),
    .crop_height(in_ch.crop_height),
    .geom       (geom_in)
  );

  assign col_end  = ({1'b0, col_r} + 9'd1) >= s1_r.w;
  assign row_end  = ({1'b0, row_r} + 10'd1) >= s1_r.h;
  assign s1_last  = col_end && row_end;
  assign s1_go    = s1_valid_r && (!s1_last || !out_valid_r || out_ch.ready);
  assign out_load = s1_go && s1_last;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // segment sampling
  always_comb begin
    flags_upd = flags_r;
    if (s1_r.lit) begin
      if (col_r == s1_r.xh) begin
        priority if (row_r < {1'b0, s1_r.t1}) begin
          flags_upd[SEG_A] = 1'b1;
        end else if (row_r == {1'b0, s1_r.t1}) begin
          flags_upd[SEG_A] = flags_r[SEG_A];
        end else if (row_r < s1_r.t2) begin
          flags_upd[SEG_G] = 1'b1;
        end else begin
          flags_upd[SEG_D] = 1'b1;
        end
      end
      if (row_r == {1'b0, s1_r.t1}) begin
        if (col_r < s1_r.xh) begin
          flags_upd[SEG_F] = 1'b1;
        end else begin
          flags_upd[SEG_B] = 1'b1;
        end
      end
      if (row_r == s1_r.t2) begin
        if (col_r < s1_r.xh) begin
          flags_upd[SEG_E] = 1'b1;
        end else begin
          flags_upd[SEG_C] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    flags_nxt = flags_r;
    if (s1_go) begin
      flags_nxt = s1_last ? '0 : flags_upd;
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 9'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end
  end

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_go);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= geom_in;
    end
    if (out_load) begin
      out_digit_r <= classify(s1_r.w, s1_r.h, flags_upd);
      out_segs_r  <= flags_upd;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.digit    = out_digit_r;
  assign out_ch.segments = out_segs_r;

  `SSDR_ASSERT(a_clear_after_crop, out_load |=> (col_r == '0 && row_r == '0 && flags_r == '0), "crop state not cleared after result")
  `SSDR_ASSERT(a_stall_cause, !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready), "input stalled without a blocked result")
  `SSDR_ASSERT(a_idle_holds, !s1_go |=> ($stable(col_r) && $stable(row_r) && $stable(flags_r)), "counters moved without a pixel")
  `SSDR_ASSERT_ALWAYS(a_digit_range, out_valid_r |-> out_digit_r <= DIGIT_BAD, "digit code out of range")

endmodule

### rtl/core/ssdr_geom.sv
`timescale 1ns / 1ps

module ssdr_geom
  import ssdr_pkg::*;
(
  input  logic [7:0] pixel,
  input  logic [8:0] crop_width,
  input  logic [9:0] crop_height,
  output geom_t      geom
);

  logic [8:0]  w;
  logic [9:0]  h;
  logic [10:0] h2;
  logic [20:0] t1_prod;
  logic [21:0] t2_prod;

  // clamp sizes to their legal ranges
  always_comb begin
    if (crop_width == '0) begin
      w = 9'd1;
    end else if (crop_width > 9'(MAX_WIDTH)) begin
      w = 9'(MAX_WIDTH);
    end else begin
      w = crop_width;
    end
    if (crop_height == '0) begin
      h = 10'd1;
    end else if (crop_height > 10'(MAX_HEIGHT)) begin
      h = 10'(MAX_HEIGHT);
    end else begin
      h = crop_height;
    end
  end

  assign h2      = {h, 1'b0};
  assign t1_prod = 21'(h) * 21'(RECIP3);
  assign t2_prod = 22'(h2) * 22'(RECIP3);

  assign geom.lit = (pixel == LIT_VALUE);
  assign geom.w   = w;
  assign geom.h   = h;
  assign geom.xh  = w[8:1];
  assign geom.t1  = t1_prod[RECIP3_SHIFT +: 8];
  assign geom.t2  = t2_prod[RECIP3_SHIFT +: 9];

endmodule
